// ===== rtl/swq_pkg.sv =====
package swq_pkg;

	localparam int MAX_SLEEPERS_DEF = 16;
	localparam int TIME_BITS_DEF    = 32;

	localparam int ID_W         = 4;
	localparam int TICKS_W      = 32;
	localparam int KIND_W       = 3;
	localparam int RESULT_LIMIT = 16;

	localparam logic OP_SLEEP = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_QUEUED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ZERO   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WOKEN  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

endpackage

// ===== rtl/swq_ram.sv =====
module swq_ram #(
	parameter int DEPTH = swq_pkg::MAX_SLEEPERS_DEF,
	parameter int WIDTH = swq_pkg::TIME_BITS_DEF + swq_pkg::ID_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sleep_wakeup_queue.sv =====
// zero-tick and table-full requests: result in the next cycle, busy stays low
// sleep request: result at the end of the insertion walk, which moves later entries up one
// at a time over the single-port-read entry memory (ST_INS_RD, ST_INS, ST_PUT)
// tick: after ST_TK_RD and ST_TK, a none-woken result or woken results back to back
// results are single-cycle strobes; the receiver cannot stall, busy holds off new transactions
// arst_n clears time, count and pointers; entry memory is left uninitialized
module sleep_wakeup_queue #(
	parameter int MAX_SLEEPERS = swq_pkg::MAX_SLEEPERS_DEF,
	parameter int TIME_BITS    = swq_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [swq_pkg::ID_W-1:0]    thread_id,
	input  logic [swq_pkg::TICKS_W-1:0] sleep_ticks,
	output logic                        valid,
	output logic [swq_pkg::KIND_W-1:0]  kind,
	output logic [swq_pkg::ID_W-1:0]    woken_id,
	output logic                        last
);

	localparam int IDX_W = $clog2(MAX_SLEEPERS);
	localparam int CNT_W = $clog2(MAX_SLEEPERS + 1);
	localparam int ENT_W = TIME_BITS + swq_pkg::ID_W;
	localparam int SUM_W = ((TIME_BITS > swq_pkg::TICKS_W) ? TIME_BITS : swq_pkg::TICKS_W) + 1;
	localparam int N_W   = $clog2(swq_pkg::RESULT_LIMIT + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SLEEPERS - 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS,
		ST_PUT,
		ST_TK_RD,
		ST_TK
	} state_t;

	state_t                     state_q;
	logic [TIME_BITS-1:0]       cur_q;
	logic [IDX_W-1:0]           head_q;
	logic [IDX_W-1:0]           tail_q;
	logic [CNT_W-1:0]           count_q;
	logic [IDX_W-1:0]           ptr_q;
	logic [CNT_W-1:0]           rem_q;
	logic [TIME_BITS-1:0]       wake_q;
	logic [swq_pkg::ID_W-1:0]   id_q;
	logic [N_W-1:0]             n_q;
	logic                       pend_q;
	logic [swq_pkg::ID_W-1:0]   pend_id_q;
	logic                       valid_q;
	logic [swq_pkg::KIND_W-1:0] kind_q;
	logic [swq_pkg::ID_W-1:0]   woken_id_q;
	logic                       last_q;

	logic [IDX_W-1:0]         ptr_inc;
	logic [IDX_W-1:0]         ptr_dec;
	logic [IDX_W-1:0]         head_inc;
	logic [IDX_W-1:0]         tail_inc;
	logic [IDX_W-1:0]         tail_dec;
	logic [SUM_W-1:0]         sum;
	logic [TIME_BITS-1:0]     wake_sat;
	logic                     accept;
	logic [IDX_W-1:0]         rd_addr;
	logic [ENT_W-1:0]         rd_data;
	logic [TIME_BITS-1:0]     rd_wake;
	logic [swq_pkg::ID_W-1:0] rd_id;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [ENT_W-1:0]         wr_data;
	logic                     later;
	logic                     due;

	assign ptr_inc  = (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;
	assign ptr_dec  = (ptr_q == '0) ? IDX_LAST : ptr_q - 1'b1;
	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	assign sum      = SUM_W'(cur_q) + SUM_W'(sleep_ticks);
	assign wake_sat = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];

	assign accept  = start && (state_q == ST_IDLE);
	assign rd_wake = rd_data[swq_pkg::ID_W +: TIME_BITS];
	assign rd_id   = rd_data[swq_pkg::ID_W-1:0];
	assign later   = rd_wake > wake_q;
	assign due     = (count_q != '0) && (n_q != N_W'(swq_pkg::RESULT_LIMIT))
		&& (rd_wake <= cur_q);

	always_comb begin
		unique case (state_q)
			ST_INS:   rd_addr = ptr_dec;
			ST_TK_RD: rd_addr = head_q;
			ST_TK:    rd_addr = head_inc;
			default:  rd_addr = ptr_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_inc;
		wr_data = {wake_q, id_q};
		unique case (state_q)
			ST_INS: begin
				wr_en = 1'b1;
				if (later) begin
					wr_data = rd_data;
				end
			end
			ST_PUT:  wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	swq_ram #(
		.DEPTH(MAX_SLEEPERS),
		.WIDTH(ENT_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			rem_q      <= '0;
			wake_q     <= '0;
			id_q       <= '0;
			n_q        <= '0;
			pend_q     <= 1'b0;
			pend_id_q  <= '0;
			valid_q    <= 1'b0;
			kind_q     <= swq_pkg::KIND_NONE;
			woken_id_q <= '0;
			last_q     <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == swq_pkg::OP_TICK) begin
							if (cur_q != TIME_MAX) begin
								cur_q <= cur_q + 1'b1;
							end
							n_q     <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_TK_RD;
						end else if (sleep_ticks == '0) begin
							valid_q    <= 1'b1;
							kind_q     <= swq_pkg::KIND_ZERO;
							woken_id_q <= thread_id;
							last_q     <= 1'b1;
						end else if (count_q == CNT_W'(MAX_SLEEPERS)) begin
							valid_q    <= 1'b1;
							kind_q     <= swq_pkg::KIND_FULL;
							woken_id_q <= thread_id;
							last_q     <= 1'b1;
						end else begin
							wake_q  <= wake_sat;
							id_q    <= thread_id;
							ptr_q   <= tail_dec;
							rem_q   <= count_q;
							state_q <= (count_q == '0) ? ST_PUT : ST_INS_RD;
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					if (later) begin
						ptr_q <= ptr_dec;
						rem_q <= rem_q - 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_PUT;
						end
					end else begin
						tail_q     <= tail_inc;
						count_q    <= count_q + 1'b1;
						valid_q    <= 1'b1;
						kind_q     <= swq_pkg::KIND_QUEUED;
						woken_id_q <= id_q;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_PUT: begin
					tail_q     <= tail_inc;
					count_q    <= count_q + 1'b1;
					valid_q    <= 1'b1;
					kind_q     <= swq_pkg::KIND_QUEUED;
					woken_id_q <= id_q;
					last_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_TK_RD: begin
					state_q <= ST_TK;
				end
				ST_TK: begin
					if (due) begin
						if (pend_q) begin
							valid_q    <= 1'b1;
							kind_q     <= swq_pkg::KIND_WOKEN;
							woken_id_q <= pend_id_q;
							last_q     <= 1'b0;
						end
						pend_q    <= 1'b1;
						pend_id_q <= rd_id;
						head_q    <= head_inc;
						count_q   <= count_q - 1'b1;
						n_q       <= n_q + 1'b1;
					end else begin
						valid_q <= 1'b1;
						last_q  <= 1'b1;
						if (pend_q) begin
							kind_q     <= swq_pkg::KIND_WOKEN;
							woken_id_q <= pend_id_q;
						end else begin
							kind_q     <= swq_pkg::KIND_NONE;
							woken_id_q <= '0;
						end
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = state_q != ST_IDLE;
	assign valid    = valid_q;
	assign kind     = kind_q;
	assign woken_id = woken_id_q;
	assign last     = last_q;

endmodule

// ===== rtl/swq_checker.sv =====
module swq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        opcode,
	input logic [swq_pkg::TICKS_W-1:0] sleep_ticks,
	input logic                        valid,
	input logic [swq_pkg::KIND_W-1:0]  kind,
	input logic [swq_pkg::ID_W-1:0]    woken_id,
	input logic                        last
);

	// every transaction ends in a last result that frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("last result while still busy");

	// a woken chain runs in consecutive cycles until its last result
	a_woken_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy && kind == swq_pkg::KIND_WOKEN
		##1 valid && kind == swq_pkg::KIND_WOKEN)
		else $error("broken woken chain");

	// zero-tick sleep answers in the next cycle
	a_zero_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == swq_pkg::OP_SLEEP && sleep_ticks == '0
		|=> valid && last && kind == swq_pkg::KIND_ZERO && !busy)
		else $error("zero-tick sleep not answered");

	// a tick never answers in the cycle right after its transaction
	a_tick_walk: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == swq_pkg::OP_TICK |=> busy && !valid)
		else $error("tick did not start the release walk");

	a_none_id: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == swq_pkg::KIND_NONE |-> last && woken_id == '0)
		else $error("bad none-woken result");

endmodule

bind sleep_wakeup_queue swq_checker u_swq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.opcode     (opcode),
	.sleep_ticks(sleep_ticks),
	.valid      (valid),
	.kind       (kind),
	.woken_id   (woken_id),
	.last       (last)
);
